>>> rtl/msrs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msrs_pkg: shared types and constants for the mirrored stripe splitter
// Beat layouts of both channels, register map, reset values and divider
// result bundle.
// ----------------------------------------------------------------------------
package msrs_pkg;

  localparam int MAX_PRIMARY_DEF = 8;
  localparam int ADDR_BITS_DEF   = 32;

  localparam int OFF_W    = 32;  // start offset and device offset width
  localparam int LEN_W    = 16;  // request and chunk length width
  localparam int STRIPE_W = 21;  // stripe size register width
  localparam int PCNT_W   = 4;   // primary count register width
  localparam int ROW_W    = 21;  // stripe index range for a 32-bit offset at min stripe

  localparam logic [STRIPE_W-1:0] STRIPE_MIN   = 21'd2048;
  localparam logic [STRIPE_W-1:0] STRIPE_MAX   = 21'd1048576;
  localparam logic [STRIPE_W-1:0] STRIPE_RESET = 21'd4096;
  localparam logic [PCNT_W-1:0]   PCNT_RESET   = 4'd1;

  // register index (byte address bit 2)
  localparam logic REG_STRIPE_BYTES  = 1'b0;
  localparam logic REG_PRIMARY_COUNT = 1'b1;

  typedef struct packed {
    logic             mode;
    logic [OFF_W-1:0] start_offset;
    logic [LEN_W-1:0] request_length;
  } in_item_t;

  typedef struct packed {
    logic             op_kind;
    logic [2:0]       primary_device;
    logic [3:0]       mirror_device;
    logic [OFF_W-1:0] device_offset;
    logic [LEN_W-1:0] chunk_length;
    logic [LEN_W-1:0] buffer_position;
    logic             last_chunk;
  } out_item_t;

  typedef struct packed {
    logic                done;
    logic [OFF_W-1:0]    quotient;
    logic [STRIPE_W-1:0] remainder;
  } div_res_t;

endpackage
`default_nettype wire

>>> rtl/msrs_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msrs_div: iterative restoring divider
// 32-bit dividend by 21-bit divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module msrs_div
  import msrs_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic [OFF_W-1:0]    dividend,
  input  wire logic [STRIPE_W-1:0] divisor,
  output div_res_t                 res
);

  localparam int CNT_W = $clog2(OFF_W + 1);

  logic                busy_r;
  logic                done_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [OFF_W-1:0]    dvd_r;
  logic [STRIPE_W-1:0] rem_r;
  logic [STRIPE_W-1:0] dvr_r;

  logic [STRIPE_W:0]   shifted;
  logic                fits;
  logic [STRIPE_W:0]   diff;

  assign shifted = {rem_r, dvd_r[OFF_W-1]};
  assign fits    = shifted >= {1'b0, dvr_r};
  assign diff    = shifted - {1'b0, dvr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= !start && busy_r && (cnt_r == CNT_W'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(OFF_W);
        dvd_r  <= dividend;
        dvr_r  <= divisor;
        rem_r  <= '0;
      end else if (busy_r) begin
        rem_r <= fits ? diff[STRIPE_W-1:0] : shifted[STRIPE_W-1:0];
        dvd_r <= {dvd_r[OFF_W-2:0], fits};
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign res.done      = done_r;
  assign res.quotient  = dvd_r;
  assign res.remainder = rem_r;

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider started while busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("done without a running division");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> rem_r < dvr_r)
    else $error("remainder not below divisor");

endmodule
`default_nettype wire

>>> rtl/mirrored_stripe_request_splitter_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mirrored_stripe_request_splitter_core: striped mirror request splitter
// Cuts a byte request at stripe boundaries into chunk commands for a
// primary device and its mirror.
// ----------------------------------------------------------------------------
// in_*  : one beat per request (mode, start offset, length), valid/ready.
// out_* : one beat per chunk, in ascending offset order, last_chunk on the
//         final one. A zero-length request is taken and produces no beat.
// APB   : stripe_bytes at 0x0, primary_count at 0x4; out-of-range values are
//         clamped when used. Write only while no request is in flight.
// Timing: the request is taken when idle; one shared 32-step divider runs
//   twice (offset by stripe size, then stripe index by primary count),
//   followed by a multiply step, then the first chunk beat is loaded into
//   the output register. Further chunks follow one per cycle while the output
//   is not stalled. in_ready is low until the request's last chunk has been
//   loaded into the output register.
// Stall: a stalled output beat holds; chunk generation pauses behind it.
// Reset: synchronous, active low; registers return to 4096 bytes per
//   stripe and one primary device, both channels go idle.
// ----------------------------------------------------------------------------
module mirrored_stripe_request_splitter_core
  import msrs_pkg::*;
#(
  parameter int MAX_PRIMARY = MAX_PRIMARY_DEF,
  parameter int ADDR_BITS   = ADDR_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_item_t    in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_item_t        out_data,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int PRIM_W = (MAX_PRIMARY > 1) ? $clog2(MAX_PRIMARY) : 1;
  localparam int PC_W   = $clog2(MAX_PRIMARY + 1);
  localparam logic [OFF_W-1:0] ADDR_MASK = (ADDR_BITS >= OFF_W) ? {OFF_W{1'b1}} :
                                           OFF_W'((64'd1 << ADDR_BITS) - 64'd1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV_OFF,
    S_DIV_IDX,
    S_MUL,
    S_EMIT
  } state_t;

  // configuration registers
  logic [STRIPE_W-1:0] stripe_cfg_r;
  logic [PCNT_W-1:0]   pcnt_cfg_r;
  logic                cfg_wr;
  logic                reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stripe_cfg_r <= STRIPE_RESET;
      pcnt_cfg_r   <= PCNT_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_STRIPE_BYTES:  stripe_cfg_r <= pwdata[STRIPE_W-1:0];
        REG_PRIMARY_COUNT: pcnt_cfg_r   <= pwdata[PCNT_W-1:0];
        default:           stripe_cfg_r <= stripe_cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_STRIPE_BYTES:  prdata = 32'(stripe_cfg_r);
      REG_PRIMARY_COUNT: prdata = 32'(pcnt_cfg_r);
      default:           prdata = '0;
    endcase
  end

  // clamped configuration
  logic [STRIPE_W-1:0] stripe_eff;
  logic [7:0]          pcnt8;
  logic [PC_W-1:0]     prims_eff;

  always_comb begin
    priority if (stripe_cfg_r < STRIPE_MIN) stripe_eff = STRIPE_MIN;
    else if (stripe_cfg_r > STRIPE_MAX)     stripe_eff = STRIPE_MAX;
    else                                    stripe_eff = stripe_cfg_r;
  end

  assign pcnt8 = 8'(pcnt_cfg_r);

  always_comb begin
    priority if (pcnt8 == 8'd0)            prims_eff = PC_W'(1);
    else if (pcnt8 > 8'(MAX_PRIMARY))      prims_eff = PC_W'(MAX_PRIMARY);
    else                                   prims_eff = PC_W'(pcnt_cfg_r);
  end

  // sequencer
  state_t              state_r;
  logic                div_start_r;
  logic [OFF_W-1:0]    div_dvd_r;
  logic [STRIPE_W-1:0] div_dvr_r;
  div_res_t            div_res;

  logic                mode_r;
  logic [LEN_W-1:0]    rem_r;
  logic [LEN_W-1:0]    pos_r;
  logic [STRIPE_W-1:0] within_r;
  logic [PRIM_W-1:0]   prim_r;
  logic [ROW_W-1:0]    row_r;
  logic [OFF_W-1:0]    base_r;
  logic                out_valid_r;
  out_item_t           out_data_r;

  msrs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start_r),
    .dividend (div_dvd_r),
    .divisor  (div_dvr_r),
    .res      (div_res)
  );

  // chunk datapath
  logic [STRIPE_W-1:0] avail;
  logic                take_all;
  logic [LEN_W-1:0]    take;
  logic [7:0]          prim8;
  logic [7:0]          mirr8;
  logic                prim_wrap;
  logic                out_free;
  out_item_t           chunk;

  assign avail     = stripe_eff - within_r;
  assign take_all  = STRIPE_W'(rem_r) <= avail;
  assign take      = take_all ? rem_r : avail[LEN_W-1:0];
  assign prim8     = 8'(prim_r);
  assign mirr8     = 8'(prims_eff) + prim8;
  assign prim_wrap = (prim8 + 8'd1) == 8'(prims_eff);
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    chunk.op_kind         = mode_r;
    chunk.primary_device  = prim8[2:0];
    chunk.mirror_device   = mirr8[3:0];
    chunk.device_offset   = (base_r + OFF_W'(within_r)) & ADDR_MASK;
    chunk.chunk_length    = take;
    chunk.buffer_position = pos_r;
    chunk.last_chunk      = take_all;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      div_start_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      div_start_r <= ((state_r == S_IDLE) && in_valid &&
                      (in_data.request_length != '0)) ||
                     ((state_r == S_DIV_OFF) && div_res.done);
      if ((state_r == S_EMIT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            mode_r <= in_data.mode;
            rem_r  <= in_data.request_length;
            pos_r  <= '0;
            if (in_data.request_length != '0) begin
              div_dvd_r <= in_data.start_offset & ADDR_MASK;
              div_dvr_r <= stripe_eff;
              state_r   <= S_DIV_OFF;
            end
          end
        end
        S_DIV_OFF: begin
          if (div_res.done) begin
            within_r  <= div_res.remainder;
            div_dvd_r <= div_res.quotient;
            div_dvr_r <= STRIPE_W'(prims_eff);
            state_r   <= S_DIV_IDX;
          end
        end
        S_DIV_IDX: begin
          if (div_res.done) begin
            prim_r  <= div_res.remainder[PRIM_W-1:0];
            row_r   <= div_res.quotient[ROW_W-1:0];
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          base_r  <= OFF_W'(row_r * stripe_eff);
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            out_data_r  <= chunk;
            rem_r       <= rem_r - take;
            pos_r       <= pos_r + take;
            if (take_all) begin
              state_r <= S_IDLE;
            end else begin
              // chunk ran to the stripe end: step to the next stripe
              within_r <= '0;
              if (prim_wrap) begin
                prim_r <= '0;
                base_r <= base_r + OFF_W'(stripe_eff);
              end else begin
                prim_r <= prim_r + PRIM_W'(1);
              end
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_zero_len_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.request_length == '0) |=> state_r == S_IDLE)
    else $error("zero-length request left the idle state");

  a_emit_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT |-> rem_r != '0)
    else $error("emitting with no bytes left");

  a_within_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT |-> within_r < stripe_eff)
    else $error("stripe offset outside stripe");

  a_prim_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT |-> prim8 < 8'(prims_eff))
    else $error("primary index outside device count");

  a_chunk_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_data_r.chunk_length != '0)
    else $error("empty chunk beat");

endmodule
`default_nettype wire
